// ===== rtl/crse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the Catmull-Rom spline evaluator.
// No dependencies; every other file of the block but the queue imports this package.
package crse_pkg;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUBE,
    ST_WGT,
    ST_DRAIN,
    ST_SUM,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic busy;
    logic out_load;
  } back_stat_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== rtl/catmull_rom_spline_evaluator_top.sv =====
`timescale 1ns / 1ps
// Push beat: the engine shifts it into the window once at the queue head; pushes flow at one per
// cycle while the engine is idle. Evaluate beat: from queue head to result register the engine
// runs square, cube, eight weights on the shared weight multiplier, the drain and sum states of
// the MAC pipeline and the result load; it takes no new beat until that result is loaded.
// Reset clears the control-point window to zero, sets tension to 0.5 and empties the queue.
module catmull_rom_spline_evaluator_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int InFieldW   = 3 * COORD_WIDTH + FRAC_BITS + 1,
  localparam int InDataW    = ((InFieldW + 7) / 8) * 8,
  localparam int OutFieldW  = 6 * COORD_WIDTH,
  localparam int OutDataW   = ((OutFieldW + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [FRAC_BITS:0]   cfg_wr_data,  // tension
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InDataW-1:0]   in_tdata,     // point_x, point_y, point_z, t_param
  input  logic [0:0]           in_tuser,     // cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutDataW-1:0]  out_tdata     // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z
);
  import crse_pkg::*;

  localparam int EntryW = 3 * COORD_WIDTH + FRAC_BITS + 2;
  localparam int PW     = FRAC_BITS + 1;
  localparam logic [PW-1:0] Unit = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] Half = {2'b01, {(FRAC_BITS-1){1'b0}}};

  logic [PW-1:0]        tension_r, tension_nxt, tension_clamp;
  logic                 q_push, q_full, q_empty;
  logic [EntryW-1:0]    q_wr_data, q_rd_data;
  back_stat_t           stat;
  logic [OutFieldW-1:0] out_fields;

  assign tension_nxt   = cfg_wr_en ? cfg_wr_data : tension_r;
  assign tension_clamp = (tension_r > Unit) ? Unit : tension_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= Half;
    end else begin
      tension_r <= tension_nxt;
    end
  end

  crse_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (cmd_t'(in_tuser[0])),
    .in_point (in_tdata[3*COORD_WIDTH-1:0]),
    .in_t     (in_tdata[3*COORD_WIDTH +: PW]),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_entry  (q_wr_data)
  );

  crse_fifo #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (stat.pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  crse_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tension   (tension_clamp),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_fields)
  );

  assign out_tdata = OutDataW'(out_fields);

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_empty)
    else $error("queue empty after a write");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> !q_empty)
    else $error("engine popped an empty queue");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.pop && (q_rd_data[0] == CMD_EVAL)) |=> stat.busy)
    else $error("evaluate beat did not start the engine");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(stat.out_load))
    else $error("result appeared without a load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before it was taken");

endmodule

// ===== rtl/crse_front.sv =====
`timescale 1ns / 1ps
// Front end: input register that classifies each beat and clamps t to 1.0.
// Depends on crse_pkg; feeds the command queue.
module crse_front #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int EntryW     = 3 * COORD_WIDTH + FRAC_BITS + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  crse_pkg::cmd_t             in_cmd,
  input  logic [3*COORD_WIDTH-1:0]   in_point,
  input  logic [FRAC_BITS:0]         in_t,
  output logic                       q_push,
  input  logic                       q_full,
  output logic [EntryW-1:0]          q_entry
);
  import crse_pkg::*;

  localparam int PW = FRAC_BITS + 1;
  localparam logic [PW-1:0] Unit = {1'b1, {FRAC_BITS{1'b0}}};

  logic              vld_r, vld_nxt;
  logic [EntryW-1:0] entry_r, entry_nxt;
  logic [PW-1:0]     t_clamp;

  assign in_ready = !vld_r || !q_full;
  assign q_push   = vld_r && !q_full;
  assign q_entry  = entry_r;
  assign t_clamp  = (in_t > Unit) ? Unit : in_t;

  always_comb begin
    vld_nxt   = vld_r;
    entry_nxt = entry_r;
    if (q_push) begin
      vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
      if (in_cmd == CMD_EVAL) begin
        entry_nxt = {t_clamp, {(3*COORD_WIDTH){1'b0}}, in_cmd};
      end else begin
        entry_nxt = {{PW{1'b0}}, in_point, in_cmd};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/crse_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the evaluation engine.
// Depends on nothing; depth and width come from the instantiating module.
module crse_fifo #(
  parameter int WIDTH   = 8,
  parameter int DEPTH   = 2,
  localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == (PtrW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/crse_back.sv =====
`timescale 1ns / 1ps
// Evaluation engine: control-point window, shared weight multiplier and
// three per-axis multiply-accumulate lanes with the result register.
// Depends on crse_pkg; takes its work from the command queue.
module crse_back #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int EntryW     = 3 * COORD_WIDTH + FRAC_BITS + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [FRAC_BITS:0]         tension,
  input  logic                       q_empty,
  input  logic [EntryW-1:0]          q_data,
  output crse_pkg::back_stat_t       stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [6*COORD_WIDTH-1:0]   out_data
);
  import crse_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = FRAC_BITS + 1;
  localparam int EW = FRAC_BITS + 6;
  localparam int WW = FRAC_BITS + 5;
  localparam int MW = CW + WW;
  localparam int AW = MW + 2;
  localparam int RW = AW - FRAC_BITS;
  localparam int NumWeights = 8;

  localparam logic signed [2*EW-1:0] HalfP = (2*EW)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [AW-1:0]   HalfA = AW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [EW-1:0]   UnitE = EW'(1) <<< FRAC_BITS;
  localparam logic signed [EW-1:0]   K2 = EW'(2);
  localparam logic signed [EW-1:0]   K3 = EW'(3);
  localparam logic signed [EW-1:0]   K4 = EW'(4);
  localparam logic signed [EW-1:0]   K6 = EW'(6);
  localparam logic [CW-1:0] MaxC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MinC = {1'b1, {(CW-1){1'b0}}};

  back_state_t state_r, state_nxt;
  logic [2:0]  j_r, j_nxt;
  logic [PW-1:0] t_r, t_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic signed [CW-1:0] win_r [4][3];
  logic signed [CW-1:0] win_nxt [4][3];
  logic signed [WW-1:0] w_r, w_nxt;
  logic        w_vld_r, w_vld_nxt;
  logic [2:0]  w_idx_r, w_idx_nxt;
  logic signed [MW-1:0] prod_r [3];
  logic signed [MW-1:0] prod_nxt [3];
  logic        p_vld_r;
  logic [2:0]  p_idx_r;
  logic signed [AW-1:0] pos_acc_r [3];
  logic signed [AW-1:0] pos_acc_nxt [3];
  logic signed [AW-1:0] tan_acc_r [3];
  logic signed [AW-1:0] tan_acc_nxt [3];
  logic        out_vld_r, out_vld_nxt;
  logic [6*CW-1:0] out_data_r, out_data_nxt;

  cmd_t          head_cmd;
  logic [PW-1:0] head_t;
  logic signed [EW-1:0] ts, t2s, t3s, as_e, poly, base, wsum;
  logic signed [EW-1:0] mul_a, mul_b, mul_rnd;
  logic signed [2*EW-1:0] mul_p, mul_sum, mul_shr;

  function automatic logic [CW-1:0] sat_round(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] s;
    logic [RW-1:0]        r;
    logic [RW-CW:0]       hi;
    s  = (v + HalfA) >>> FRAC_BITS;
    r  = s[RW-1:0];
    hi = r[RW-1:CW-1];
    if (&hi || ~|hi) begin
      return r[CW-1:0];
    end else if (r[RW-1]) begin
      return MinC;
    end else begin
      return MaxC;
    end
  endfunction

  assign head_cmd = cmd_t'(q_data[0]);
  assign head_t   = q_data[3*CW+1 +: PW];
  assign ts       = EW'(t_r);
  assign t2s      = EW'(t2_r);
  assign t3s      = EW'(t3_r);
  assign as_e     = EW'(tension);

  always_comb begin
    poly = '0;
    base = '0;
    unique case (j_r)
      3'd0: poly = K2 * t2s - t3s - ts;
      3'd1: begin
        poly = t2s - t3s;
        base = K2 * t3s - K3 * t2s + UnitE;
      end
      3'd2: begin
        poly = t3s - K2 * t2s + ts;
        base = K3 * t2s - K2 * t3s;
      end
      3'd3: poly = t3s - t2s;
      3'd4: poly = K4 * ts - K3 * t2s - UnitE;
      3'd5: begin
        poly = K2 * ts - K3 * t2s;
        base = K6 * t2s - K6 * ts;
      end
      3'd6: begin
        poly = K3 * t2s - K4 * ts + UnitE;
        base = K6 * ts - K6 * t2s;
      end
      3'd7: poly = K3 * t2s - K2 * ts;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        mul_a = EW'(head_t);
        mul_b = EW'(head_t);
      end
      ST_CUBE: begin
        mul_a = t2s;
        mul_b = ts;
      end
      default: begin
        mul_a = as_e;
        mul_b = poly;
      end
    endcase
    mul_p   = mul_a * mul_b;
    mul_sum = mul_p + HalfP;
    mul_shr = mul_sum >>> FRAC_BITS;
    mul_rnd = mul_shr[EW-1:0];
    wsum    = base + mul_rnd;
  end

  always_comb begin
    state_nxt    = state_r;
    j_nxt        = j_r;
    t_nxt        = t_r;
    t2_nxt       = t2_r;
    t3_nxt       = t3_r;
    w_nxt        = w_r;
    w_vld_nxt    = 1'b0;
    w_idx_nxt    = w_idx_r;
    win_nxt      = win_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    stat         = '0;
    stat.busy    = (state_r != ST_IDLE);

    for (int k = 0; k < 3; k++) begin
      prod_nxt[k]    = win_r[w_idx_r[1:0]][k] * w_r;
      pos_acc_nxt[k] = pos_acc_r[k];
      tan_acc_nxt[k] = tan_acc_r[k];
      if (p_vld_r) begin
        if (p_idx_r[2]) begin
          tan_acc_nxt[k] = tan_acc_r[k] + AW'(prod_r[k]);
        end else begin
          pos_acc_nxt[k] = pos_acc_r[k] + AW'(prod_r[k]);
        end
      end
    end

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          stat.pop = 1'b1;
          if (head_cmd == CMD_EVAL) begin
            t_nxt     = head_t;
            t2_nxt    = mul_rnd[PW-1:0];
            state_nxt = ST_CUBE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              win_nxt[i] = win_r[i+1];
            end
            for (int k = 0; k < 3; k++) begin
              win_nxt[3][k] = q_data[1+k*CW +: CW];
            end
          end
        end
      end
      ST_CUBE: begin
        t3_nxt    = mul_rnd[PW-1:0];
        j_nxt     = '0;
        state_nxt = ST_WGT;
        for (int k = 0; k < 3; k++) begin
          pos_acc_nxt[k] = '0;
          tan_acc_nxt[k] = '0;
        end
      end
      ST_WGT: begin
        w_nxt     = wsum[WW-1:0];
        w_vld_nxt = 1'b1;
        w_idx_nxt = j_r;
        j_nxt     = j_r + 1'b1;
        if (j_r == 3'(NumWeights - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_vld_r || out_ready) begin
          stat.out_load = 1'b1;
          out_vld_nxt   = 1'b1;
          out_data_nxt  = {sat_round(tan_acc_r[2]), sat_round(tan_acc_r[1]),
                           sat_round(tan_acc_r[0]), sat_round(pos_acc_r[2]),
                           sat_round(pos_acc_r[1]), sat_round(pos_acc_r[0])};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      j_r       <= '0;
      w_vld_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      win_r     <= '{default: '0};
    end else begin
      state_r   <= state_nxt;
      j_r       <= j_nxt;
      w_vld_r   <= w_vld_nxt;
      p_vld_r   <= w_vld_r;
      out_vld_r <= out_vld_nxt;
      win_r     <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    t2_r       <= t2_nxt;
    t3_r       <= t3_nxt;
    w_r        <= w_nxt;
    w_idx_r    <= w_idx_nxt;
    p_idx_r    <= w_idx_r;
    prod_r     <= prod_nxt;
    pos_acc_r  <= pos_acc_nxt;
    tan_acc_r  <= tan_acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/catmull_rom_spline_evaluator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the Catmull-Rom spline evaluator: queued stimulus, random idling,
// an in-bench fixed-point spline predictor and a beat-by-beat result checker.
// Depends on crse_pkg and catmull_rom_spline_evaluator_top.
module catmull_rom_spline_evaluator_top_tb;
  import crse_pkg::*;

  localparam int  FRAC        = 16;
  localparam int  CW          = 32;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SETTLE      = 40;
  localparam int  LONG_HOLD   = 500;
  localparam longint UNIT     = 64'sd1 << FRAC;
  localparam longint CMAX     = 64'sd2147483647;
  localparam longint CMIN     = -64'sd2147483648;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [16:0] t_param;
  } spline_beat_t;

  logic          clk         = 1'b0;
  logic          rst_n       = 1'b0;
  logic          cfg_wr_en   = 1'b0;
  logic [16:0]   cfg_wr_data = '0;
  logic          in_tvalid   = 1'b0;
  logic          in_tready;
  logic [119:0]  in_tdata    = '0;
  logic [0:0]    in_tuser    = '0;
  logic          out_tvalid;
  logic          out_tready  = 1'b0;
  logic [191:0]  out_tdata;

  spline_beat_t  pending_beats[$];
  spline_beat_t  on_bus;
  logic [191:0]  expected_curve[$];
  longint        ctl_pts[4][3];
  logic [16:0]   tension_q = 17'd32768;
  int            send_gap = 0;
  int            rx_stall = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  bit            long_hold_req = 1'b0;
  bit            long_hold_taken = 1'b0;
  int            error_count = 0;
  int            cycle_count = 0;
  string         field_name[6] = '{"pos_x", "pos_y", "pos_z", "tan_x", "tan_y", "tan_z"};

  catmull_rom_spline_evaluator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint q_round(longint v);
    return (v + (UNIT >>> 1)) >>> FRAC;
  endfunction

  function automatic longint clamp_unit(logic [16:0] v);
    return (v > 17'd65536) ? UNIT : longint'(v);
  endfunction

  function automatic logic [31:0] sat_coord(longint v);
    if (v > CMAX) return CMAX[31:0];
    if (v < CMIN) return CMIN[31:0];
    return v[31:0];
  endfunction

  // The coordinate is split into whole and fractional parts so that the sum stays exact.
  function automatic longint axis_blend(longint w[4], int axis);
    longint hi_acc;
    longint lo_acc;
    longint xh;
    hi_acc = 0;
    lo_acc = 0;
    for (int i = 0; i < 4; i++) begin
      xh = ctl_pts[i][axis] >>> FRAC;
      hi_acc += xh * w[i];
      lo_acc += (ctl_pts[i][axis] - xh * UNIT) * w[i];
    end
    return hi_acc + q_round(lo_acc);
  endfunction

  task automatic track_spline(spline_beat_t b);
    longint t, a, t2, t3;
    longint wp[4];
    longint wd[4];
    logic [191:0] res;
    if (b.cmd == CMD_PUSH) begin
      for (int i = 0; i < 3; i++) ctl_pts[i] = ctl_pts[i + 1];
      ctl_pts[3][0] = longint'(signed'(b.px));
      ctl_pts[3][1] = longint'(signed'(b.py));
      ctl_pts[3][2] = longint'(signed'(b.pz));
    end else begin
      t  = clamp_unit(b.t_param);
      a  = clamp_unit(tension_q);
      t2 = q_round(t * t);
      t3 = q_round(t2 * t);
      wp[0] = q_round(a * (2 * t2 - t3 - t));
      wp[1] = 2 * t3 - 3 * t2 + UNIT + q_round(a * (t2 - t3));
      wp[2] = 3 * t2 - 2 * t3 + q_round(a * (t3 - 2 * t2 + t));
      wp[3] = q_round(a * (t3 - t2));
      wd[0] = q_round(a * (4 * t - 3 * t2 - UNIT));
      wd[1] = 6 * t2 - 6 * t + q_round(a * (2 * t - 3 * t2));
      wd[2] = 6 * t - 6 * t2 + q_round(a * (3 * t2 - 4 * t + UNIT));
      wd[3] = q_round(a * (3 * t2 - 2 * t));
      for (int k = 0; k < 3; k++) begin
        res[CW*k +: CW]     = sat_coord(axis_blend(wp, k));
        res[CW*(3+k) +: CW] = sat_coord(axis_blend(wd, k));
      end
      expected_curve.push_back(res);
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic queue_beat(cmd_t c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [16:0] tp);
    spline_beat_t b;
    b.cmd = c;
    b.px = x;
    b.py = y;
    b.pz = z;
    b.t_param = tp;
    pending_beats.push_back(b);
  endtask

  task automatic queue_random(int n, int eval_pct);
    for (int i = 0; i < n; i++)
      queue_beat(($urandom_range(0, 99) < eval_pct) ? CMD_EVAL : CMD_PUSH,
                 rand_coord(), rand_coord(), rand_coord(), rand_param());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_tvalid || expected_curve.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tension(logic [16:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    tension_q = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) track_spline(on_bus);
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        on_bus = pending_beats.pop_front();
        in_tdata  <= {7'd0, on_bus.t_param, on_bus.pz, on_bus.py, on_bus.px};
        in_tuser  <= on_bus.cmd;
        in_tvalid <= 1'b1;
        send_gap = tx_idle_on ? draw_gap() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      rx_stall = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_stall = rx_idle_on ? draw_gap() : 0;
    end
  end

  always @(posedge clk) begin
    logic [191:0] exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_curve.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        exp_beat = expected_curve.pop_front();
        for (int i = 0; i < 6; i++)
          if (out_tdata[CW*i +: CW] !== exp_beat[CW*i +: CW]) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name[i],
                     exp_beat[CW*i +: CW], out_tdata[CW*i +: CW]);
            error_count++;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) ctl_pts[i][k] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Evaluations on the cleared window, then extreme points, saturation and clamped t.
    queue_beat(CMD_EVAL, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 17'd0);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd65536);
    queue_beat(CMD_PUSH, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 17'h1ffff);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd32768);
    queue_beat(CMD_PUSH, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 17'd0);
    queue_beat(CMD_PUSH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000, 17'd0);
    queue_beat(CMD_PUSH, 32'hffff_ffff, 32'h8000_0000, 32'hfffe_8000, 17'd0);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd0);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd65536);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'h1ffff);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd1);
    queue_beat(CMD_PUSH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd0);
    queue_beat(CMD_PUSH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 17'd0);
    queue_beat(CMD_PUSH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 17'd0);
    queue_beat(CMD_PUSH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd0);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd32768);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd0);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd65536);
    queue_beat(CMD_EVAL, 32'h0, 32'h0, 32'h0, 17'd65535);
    wait_idle();

    write_tension(17'd0);
    queue_random(250, 45);
    wait_idle();

    write_tension(17'd65536);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    queue_random(250, 45);
    wait_idle();

    write_tension(17'h1ffff);
    tx_idle_on = 1'b1;
    queue_random(250, 50);
    wait_idle();

    // The receiver holds off long enough for the block to back up and stall its input.
    write_tension(17'($urandom_range(0, 131071)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    long_hold_req = 1'b1;
    queue_random(250, 70);
    wait_idle();

    write_tension(17'd1);
    queue_random(250, 45);
    wait_idle();

    write_tension(17'd32768);
    tx_idle_on = 1'b1;
    queue_random(300, 45);
    wait_idle();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
